### sv/tffc_pkg.sv
// Shared constants and divider interface types for the thermal false-colour block.
package tffc_pkg;

  // Frame geometry
  localparam int FRAME_COLUMNS = 32;
  localparam int FRAME_ROWS    = 24;
  localparam int FRAME_PIXELS  = FRAME_COLUMNS * FRAME_ROWS;
  localparam int PIX_W         = $clog2(FRAME_PIXELS);

  // Positions of the 2x2 centre block (left pixel of each of its two rows)
  localparam int CTR_A = (FRAME_ROWS / 2 - 1) * FRAME_COLUMNS + (FRAME_COLUMNS / 2 - 1);
  localparam int CTR_B = (FRAME_ROWS / 2) * FRAME_COLUMNS + (FRAME_COLUMNS / 2 - 1);

  // Colour index range and divider geometry
  localparam int IDX_FULL  = 180;
  localparam int QUO_W     = 8;
  localparam int PROD_W    = 24;

  // Divider request: start pulse with numerator and denominator
  typedef struct packed {
    logic        start;
    logic [15:0] num;
    logic [15:0] den;
  } tffc_div_req_t;

  // Divider response: done pulse with quotient, held until the next start
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } tffc_div_rsp_t;

endpackage

### sv/tffc_div.sv
// Iterative scaler: quotient of 180*num/den, one restoring subtract step per cycle.
module tffc_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tffc_pkg::tffc_div_req_t req,
  output tffc_pkg::tffc_div_rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [2:0]                   cnt_r, cnt_nxt;
  logic                         done_r, done_nxt;
  logic [15:0]                  num_r, num_nxt;
  logic [15:0]                  den_r, den_nxt;
  logic [15:0]                  rem_r, rem_nxt;
  logic [7:0]                   lo_r, lo_nxt;
  logic [tffc_pkg::QUO_W-1:0]   quo_r, quo_nxt;
  logic [tffc_pkg::PROD_W-1:0]  prod;
  logic [17:0]                  trial;
  logic                         ge;

  // Constant multiply by the index range
  assign prod = tffc_pkg::PROD_W'(num_r) * tffc_pkg::PROD_W'(tffc_pkg::IDX_FULL);

  // Shared subtractor: shift in next dividend bit and try the denominator
  assign trial = {1'b0, rem_r, lo_r[7]} - {2'b00, den_r};
  assign ge    = ~trial[17];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    lo_nxt    = lo_r;
    quo_nxt   = quo_r;
    case (state_r)
      S_IDLE: begin
        if (req.start) begin
          num_nxt   = req.num;
          den_nxt   = req.den;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // quotient is below 256, so the high part is already below den
        rem_nxt   = prod[23:8];
        lo_nxt    = prod[7:0];
        cnt_nxt   = 3'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? trial[15:0] : {rem_r[14:0], lo_r[7]};
        lo_nxt  = {lo_r[6:0], 1'b0};
        quo_nxt = {quo_r[tffc_pkg::QUO_W-2:0], ge};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 3'd0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

### sv/thermal_frame_false_colour.sv
// Thermal frame false colour: per-pixel RGB565 mapping with frame min/max/centre statistics.
// One pixel temperature is taken per item and one colour comes out for it. Each pixel is
// scaled with the min and max of the previous finished frame to an index 0..180 and mapped
// through a six-segment ramp to RGB565. Each item goes in order through loading the scaler,
// a constant multiply, eight restoring subtract steps in the shared scaler, and the move of
// its colour into the output register. The input stalls from acceptance until that move,
// which waits while a held output is stalled; a finished colour waiting in the output
// register does not hold off the next pixel. On the last pixel of a frame frame_done is set
// together with the frame's min, max and centre average; otherwise those statistics read
// zero. frame_start forces a pixel to position zero of a new frame.
module thermal_frame_false_colour (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_temperature,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_colour565,
  output logic               out_frame_done,
  output logic signed [15:0] out_frame_min,
  output logic signed [15:0] out_frame_max,
  output logic signed [15:0] out_centre_temp
);

  localparam int PW = tffc_pkg::PIX_W;

  // Index source selected at acceptance
  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_FULL = 2'd1;
  localparam logic [1:0] SEL_DIV  = 2'd2;

  // Six-segment ramp, index 0..180 to RGB565; divisions by 3 and 6 via reciprocals
  function automatic logic [15:0] ramp565(input logic [7:0] j);
    logic [7:0]  k;
    logic [19:0] p;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    k = 8'd0;
    p = 20'd0;
    r = 8'd0;
    g = 8'd0;
    b = 8'd0;
    if (j < 8'd30) begin
      b = 8'd20 + {j[5:0], 2'b00};
    end else if (j < 8'd60) begin
      k = j - 8'd30;
      r = {k[5:0], 2'b00};
      b = 8'd140 - {k[6:0], 1'b0};
    end else if (j < 8'd90) begin
      k = j - 8'd60;
      p = 20'(k) * 20'd9;
      r = 8'd120 + p[8:1];
      p = (20'd240 - 20'(k) * 20'd7) * 20'd171;
      b = p[16:9];
    end else if (j < 8'd120) begin
      k = j - 8'd90;
      r = 8'd255;
      g = {k[6:0], 1'b0};
      p = (20'd30 - 20'(k)) * 20'd171;
      b = p[16:9];
    end else if (j < 8'd150) begin
      k = j - 8'd120;
      r = 8'd255;
      p = 20'(k) * 20'd35 * 20'd683;
      g = 8'd60 + p[19:12];
    end else begin
      k = ((j > 8'd180) ? 8'd180 : j) - 8'd150;
      r = 8'd255;
      p = 20'(k) * 20'd342;
      g = 8'd235 + p[16:9];
      p = 20'(k) * 20'd17;
      b = p[8:1];
    end
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // Control
  logic                busy_r, busy_nxt;
  logic                wait_r, wait_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PW-1:0]       idx_r, idx_nxt;
  // Frame statistics
  logic signed [15:0]  rmin_r, rmin_nxt;
  logic signed [15:0]  rmax_r, rmax_nxt;
  logic signed [17:0]  csum_r, csum_nxt;
  logic signed [15:0]  smin_r, smin_nxt;
  logic signed [15:0]  smax_r, smax_nxt;
  // Per-item results carried to the output
  logic [1:0]          sel_r;
  logic                pdone_r;
  logic signed [15:0]  pmin_r, pmax_r, pavg_r;
  logic [15:0]         col_r;
  logic                odone_r;
  logic signed [15:0]  omin_r, omax_r, oavg_r;

  logic                accept;
  logic                fin;
  logic                load_out;
  logic [PW-1:0]       idx_eff;
  logic                first, last, is_ctr;
  logic signed [17:0]  csum_base;
  logic [16:0]         num_diff, den_diff;
  logic [1:0]          sel_nxt;
  logic [7:0]          cidx;
  logic signed [17:0]  avg_full;

  tffc_pkg::tffc_div_req_t div_req;
  tffc_pkg::tffc_div_rsp_t div_rsp;

  tffc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Handshake
  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign fin      = div_rsp.done || wait_r;
  assign load_out = fin && (!out_valid_r || !out_stall);

  // Frame position
  assign idx_eff = in_frame_start ? '0 : idx_r;
  assign first   = (idx_eff == '0);
  assign last    = (idx_eff == PW'(tffc_pkg::FRAME_PIXELS - 1));
  assign is_ctr  = (idx_eff == PW'(tffc_pkg::CTR_A)) || (idx_eff == PW'(tffc_pkg::CTR_A + 1)) ||
                   (idx_eff == PW'(tffc_pkg::CTR_B)) || (idx_eff == PW'(tffc_pkg::CTR_B + 1));

  // Running statistics for the accepted pixel
  assign csum_base = first ? 18'sd0 : csum_r;
  assign avg_full  = csum_nxt >>> 2;

  always_comb begin
    rmin_nxt = rmin_r;
    rmax_nxt = rmax_r;
    csum_nxt = csum_r;
    smin_nxt = smin_r;
    smax_nxt = smax_r;
    idx_nxt  = idx_r;
    if (accept) begin
      if (first) begin
        rmin_nxt = in_temperature;
        rmax_nxt = in_temperature;
      end else begin
        rmin_nxt = (in_temperature < rmin_r) ? in_temperature : rmin_r;
        rmax_nxt = (in_temperature > rmax_r) ? in_temperature : rmax_r;
      end
      csum_nxt = is_ctr ? csum_base + 18'(in_temperature) : csum_base;
      if (last) begin
        smin_nxt = rmin_nxt;
        smax_nxt = rmax_nxt;
        idx_nxt  = '0;
      end else begin
        idx_nxt = idx_eff + PW'(1);
      end
    end
  end

  // Scaling against the previous frame's extremes
  assign num_diff = 17'(in_temperature) - 17'(smin_r);
  assign den_diff = 17'(smax_r) - 17'(smin_r);

  always_comb begin
    if (smax_r <= smin_r || in_temperature < smin_r) begin
      sel_nxt = SEL_ZERO;
    end else if (in_temperature >= smax_r) begin
      sel_nxt = SEL_FULL;
    end else begin
      sel_nxt = SEL_DIV;
    end
  end

  assign div_req.start = accept;
  assign div_req.num   = num_diff[15:0];
  assign div_req.den   = den_diff[15:0];

  // Colour index selection
  always_comb begin
    case (sel_r)
      SEL_ZERO: cidx = 8'd0;
      SEL_FULL: cidx = 8'(tffc_pkg::IDX_FULL);
      SEL_DIV:  cidx = div_rsp.quo;
      default:  cidx = 8'd0;
    endcase
  end

  // Sequencing of one item
  always_comb begin
    busy_nxt      = busy_r;
    wait_nxt      = fin && !load_out;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (load_out) begin
      busy_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      rmin_r      <= '0;
      rmax_r      <= '0;
      csum_r      <= '0;
      smin_r      <= '0;
      smax_r      <= '0;
    end else begin
      busy_r      <= busy_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      rmin_r      <= rmin_nxt;
      rmax_r      <= rmax_nxt;
      csum_r      <= csum_nxt;
      smin_r      <= smin_nxt;
      smax_r      <= smax_nxt;
    end
  end

  // Item payload captured at acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      sel_r   <= sel_nxt;
      pdone_r <= last;
      pmin_r  <= last ? rmin_nxt : 16'sd0;
      pmax_r  <= last ? rmax_nxt : 16'sd0;
      pavg_r  <= last ? avg_full[15:0] : 16'sd0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      col_r   <= ramp565(cidx);
      odone_r <= pdone_r;
      omin_r  <= pmin_r;
      omax_r  <= pmax_r;
      oavg_r  <= pavg_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_colour565   = col_r;
  assign out_frame_done  = odone_r;
  assign out_frame_min   = omin_r;
  assign out_frame_max   = omax_r;
  assign out_centre_temp = oavg_r;

  // Every accepted pixel yields a scaler done pulse
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##10 div_rsp.done)
    else $error("scaler result not on schedule");

  // No scaler result without a pixel in flight
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> busy_r && !wait_r)
    else $error("scaler result without pending pixel");

  // Frame position stays inside the frame
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= PW'(tffc_pkg::FRAME_PIXELS - 1))
    else $error("pixel position out of frame");

  // Statistics read zero except on the last pixel
  a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |->
      out_frame_min == 16'sd0 && out_frame_max == 16'sd0 && out_centre_temp == 16'sd0)
    else $error("statistics set outside frame end");

endmodule
